[rtl/rvb_pkg.sv]
// Package for the radial vignette blend: fixed widths, register indexes and
// default parameter values. No dependencies.
`default_nettype none
package rvb_pkg;
   localparam int MAX_SIDE_DEFAULT     = 4096;
   localparam int CHANNEL_BITS_DEFAULT = 16;
   localparam int COORD_BITS    = 12;
   localparam int FRAME_BITS    = 13;
   localparam int RADIUS_BITS   = 20;
   localparam int INVRANGE_BITS = 25;
   localparam int AMOUNT_BITS   = 16;
   localparam int COLOR_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 25;
   localparam int DIFF_BITS     = 17;
   localparam int SQ_BITS       = 35;
   localparam int DIST_BITS     = 18;
   localparam int ONE_Q16       = 65536;
   localparam int ONE_Q24       = 16777216;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_INNER_RADIUS  = 3'd2,
      REG_INVERSE_RANGE = 3'd3,
      REG_BLEND_AMOUNT  = 3'd4,
      REG_TINT_RED      = 3'd5,
      REG_TINT_GREEN    = 3'd6,
      REG_TINT_BLUE     = 3'd7
   } reg_index_type;
endpackage
`default_nettype wire

[rtl/rvb_if.sv]
// Stream interfaces for the radial vignette blend: pixel request, pixel
// response and register write channels. Depends on rvb_pkg.
`default_nettype none
interface rvb_req_if import rvb_pkg::*; #(parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT);
   logic                    valid;
   logic                    ready;
   logic [COORD_BITS-1:0]   pixel_x;
   logic [COORD_BITS-1:0]   pixel_y;
   logic [CHANNEL_BITS-1:0] in_red;
   logic [CHANNEL_BITS-1:0] in_green;
   logic [CHANNEL_BITS-1:0] in_blue;
   logic [CHANNEL_BITS-1:0] in_alpha;
   modport source (output valid, pixel_x, pixel_y, in_red, in_green, in_blue, in_alpha,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, in_red, in_green, in_blue, in_alpha,
                 output ready);
endinterface

interface rvb_rsp_if import rvb_pkg::*; #(parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_red;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_blue;
   logic [CHANNEL_BITS-1:0] out_alpha;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface rvb_csr_if import rvb_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/radial_vignette_blend.sv]
// Radial vignette blend, top level: registers, pipeline and output stage.
// Depends on rvb_pkg, rvb_if and rvb_isqrt.
//
// Use: program the frame size, inner radius, inverse range, amount and tint
// through the csr channel while the block is idle; each csr beat writes one
// register by index, indexes beyond the list are dropped. Then stream pixels
// on the req channel, one beat per pixel with its x,y coordinates. Every req
// beat gives exactly one rsp beat, in order, with RGB blended toward the tint
// by a smoothstep of the distance from the frame centre; alpha is copied and
// a pixel with alpha zero comes back unchanged.
// Throughput is one pixel per clock while the output is not stalled. Stages
// from the req beat to the rsp beat being offered: three for the offsets and
// squares, eighteen for the square root (one result bit per stage), five for
// ramp, smoothstep and amount, and one for the blend into the output register.
// The whole pipeline, valid bits included, advances only while the output
// register is empty or being taken, so a stalled receiver freezes every
// stage and nothing is lost or repeated. req ready is this advance signal.
// Reset clears every valid bit and loads the register defaults.
`default_nettype none
module radial_vignette_blend import rvb_pkg::*; #(
   parameter int MAX_SIDE     = MAX_SIDE_DEFAULT,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   rvb_req_if.sink  req,
   rvb_rsp_if.source rsp,
   rvb_csr_if.sink  csr
);
   localparam int PRE  = 3;
   localparam int POST = 5;
   localparam int LAT  = PRE + DIST_BITS + POST;
   localparam int CB   = CHANNEL_BITS;
   // A frame register can never exceed its field, so a larger side limit never bites.
   localparam int SIDE_CAP = (MAX_SIDE > (2 ** FRAME_BITS) - 1) ? (2 ** FRAME_BITS) - 1
                                                                 : MAX_SIDE;
   localparam logic [FRAME_BITS-1:0] SIDE_MAX = FRAME_BITS'(SIDE_CAP);

   // Registers.
   logic [FRAME_BITS-1:0]    width_ff, height_ff;
   logic [RADIUS_BITS-1:0]   radius_ff;
   logic [INVRANGE_BITS-1:0] inv_ff;
   logic [AMOUNT_BITS-1:0]   amount_ff;
   logic [COLOR_BITS-1:0]    tr_ff, tg_ff, tb_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_BITS'(1920);
         height_ff <= FRAME_BITS'(1080);
         radius_ff <= '0;
         inv_ff    <= INVRANGE_BITS'(ONE_Q24);
         amount_ff <= '0;
         tr_ff <= '0; tg_ff <= '0; tb_ff <= '0;
      end else if (csr.valid) begin
         case (reg_index_type'(csr.index))
            REG_FRAME_WIDTH:   width_ff  <= csr.data[FRAME_BITS-1:0];
            REG_FRAME_HEIGHT:  height_ff <= csr.data[FRAME_BITS-1:0];
            REG_INNER_RADIUS:  radius_ff <= csr.data[RADIUS_BITS-1:0];
            REG_INVERSE_RANGE: inv_ff    <= csr.data[INVRANGE_BITS-1:0];
            REG_BLEND_AMOUNT:  amount_ff <= csr.data[AMOUNT_BITS-1:0];
            REG_TINT_RED:      tr_ff     <= csr.data[COLOR_BITS-1:0];
            REG_TINT_GREEN:    tg_ff     <= csr.data[COLOR_BITS-1:0];
            REG_TINT_BLUE:     tb_ff     <= csr.data[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Saturated operands, constant while pixels flow.
   logic [FRAME_BITS-1:0]    w_sat, h_sat;
   logic [INVRANGE_BITS-1:0] inv_sat;
   assign w_sat   = (width_ff  > SIDE_MAX) ? SIDE_MAX : width_ff;
   assign h_sat   = (height_ff > SIDE_MAX) ? SIDE_MAX : height_ff;
   assign inv_sat = (inv_ff > INVRANGE_BITS'(ONE_Q24)) ? INVRANGE_BITS'(ONE_Q24) : inv_ff;

   // Pipeline control.
   logic advance;
   logic [LAT-1:0] vld_ff;
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-2:0], req.valid};
   end

   // Pixel payload delay line, carried alongside the distance pipeline.
   logic [CB-1:0] r_ff [LAT], g_ff [LAT], b_ff [LAT], a_ff [LAT];
   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff[0] <= req.in_red;  g_ff[0] <= req.in_green;
         b_ff[0] <= req.in_blue; a_ff[0] <= req.in_alpha;
         for (int i = 1; i < LAT; i++) begin
            r_ff[i] <= r_ff[i-1]; g_ff[i] <= g_ff[i-1];
            b_ff[i] <= b_ff[i-1]; a_ff[i] <= a_ff[i-1];
         end
      end
   end

   // Stage 1: offsets from the centre in 1/16 pixel.
   logic [DIFF_BITS-1:0] dx_ff, dy_ff;
   logic [DIFF_BITS-1:0] px16, py16, cx16, cy16;
   assign px16 = {1'b0, req.pixel_x, 4'b0};
   assign py16 = {1'b0, req.pixel_y, 4'b0};
   assign cx16 = {1'b0, w_sat, 3'b0};
   assign cy16 = {1'b0, h_sat, 3'b0};
   // Stage 2: squares. Stage 3: sum.
   logic [SQ_BITS-1:0] dx2_ff, dy2_ff, sum_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= (px16 >= cx16) ? px16 - cx16 : cx16 - px16;
         dy_ff  <= (py16 >= cy16) ? py16 - cy16 : cy16 - py16;
         dx2_ff <= SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
         dy2_ff <= SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
         sum_ff <= dx2_ff + dy2_ff;
      end
   end

   logic [DIST_BITS-1:0] root_dist;
   rvb_isqrt u_isqrt (.clock(clock), .enable(advance), .radicand(sum_ff), .root(root_dist));

   // Ramp: (distance - inner) * inverse range, clamped to one.
   logic [RADIUS_BITS-1:0] excess_ff;
   logic [16:0]            v_ff;
   logic [45:0]            prod_v;
   logic [33:0]            vv_ff;
   logic [17:0]            w3_ff;
   logic [16:0]            s_ff;
   logic [15:0]            t_ff;
   logic [50:0]            s_full;
   logic [32:0]            t_full;
   logic [RADIUS_BITS-1:0] dist_ext;
   assign dist_ext = RADIUS_BITS'(root_dist);
   assign prod_v   = 46'(excess_ff) * 46'(inv_sat);
   assign s_full   = 51'(vv_ff[33:16]) * 51'(w3_ff);
   assign t_full   = 33'(s_ff) * 33'(amount_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         excess_ff <= (dist_ext > radius_ff) ? dist_ext - radius_ff : '0;
         v_ff <= (prod_v[45:12] > 34'(ONE_Q16)) ? 17'(ONE_Q16) : prod_v[28:12];
         // Smoothstep: v*v then times (3 - 2v).
         vv_ff <= 34'(v_ff) * 34'(v_ff);
         w3_ff <= 18'(3 * ONE_Q16) - {v_ff, 1'b0};
         s_ff  <= (s_full[50:16] > 35'(ONE_Q16)) ? 17'(ONE_Q16) : s_full[32:16];
         t_ff  <= t_full[31:16];
      end
   end

   // Blend toward the tint; output register.
   logic [CB-1:0] tint_r, tint_g, tint_b;
   assign tint_r = tr_ff[CB-1:0];
   assign tint_g = tg_ff[CB-1:0];
   assign tint_b = tb_ff[CB-1:0];

   function automatic logic [CB-1:0] blend(input logic [CB-1:0] c,
                                          input logic [CB-1:0] tint,
                                          input logic [15:0]   t);
      logic [33:0] acc;
      acc = 34'(c) * 34'(17'(ONE_Q16) - 17'(t)) + 34'(tint) * 34'(t) + 34'd32768;
      return acc[16 +: CB];
   endfunction

   localparam int L = LAT - 1;
   logic          out_v_ff;
   logic [CB-1:0] or_ff, og_ff, ob_ff, oa_ff;
   logic          pass;
   assign pass = (a_ff[L] == '0);
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= vld_ff[L];
      if (advance) begin
         or_ff <= pass ? r_ff[L] : blend(r_ff[L], tint_r, t_ff);
         og_ff <= pass ? g_ff[L] : blend(g_ff[L], tint_g, t_ff);
         ob_ff <= pass ? b_ff[L] : blend(b_ff[L], tint_b, t_ff);
         oa_ff <= a_ff[L];
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.out_red   = or_ff;
   assign rsp.out_green = og_ff;
   assign rsp.out_blue  = ob_ff;
   assign rsp.out_alpha = oa_ff;
endmodule
`default_nettype wire

[rtl/rvb_isqrt.sv]
// Pipelined integer square root, truncating, one result bit per stage.
// Depends on rvb_pkg; stages advance together on the enable.
`default_nettype none
module rvb_isqrt import rvb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [SQ_BITS-1:0]   radicand,
   output      logic [DIST_BITS-1:0] root
);
   localparam int STEPS = DIST_BITS;
   localparam int REM_BITS = DIST_BITS + 2;
   // Two radicand bits are consumed per result bit.
   localparam int NUM_BITS = 2 * STEPS;

   logic [NUM_BITS-1:0]  num_ff  [STEPS];
   logic [REM_BITS-1:0]  rem_ff  [STEPS];
   logic [DIST_BITS-1:0] quo_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [NUM_BITS-1:0]  num_src;
      logic [REM_BITS-1:0]  rem_src;
      logic [DIST_BITS-1:0] quo_src;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      logic [NUM_BITS-1:0]  num_in;
      if (i == 0) begin : g_first
         // The first stage starts from the radicand with an empty remainder.
         assign num_src = NUM_BITS'(radicand);
         assign rem_src = '0;
         assign quo_src = '0;
      end else begin : g_next
         assign num_src = num_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end
      always_comb begin
         // Bring down the next two bits of the radicand.
         rem_sh = {rem_src[REM_BITS-3:0], num_src[NUM_BITS-1 -: 2]};
         trial  = {quo_src, 2'b01};
         num_in = {num_src[NUM_BITS-3:0], 2'b00};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[i] <= num_in;
            if (rem_sh >= trial) begin
               rem_ff[i] <= rem_sh - trial;
               quo_ff[i] <= {quo_src[DIST_BITS-2:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_sh;
               quo_ff[i] <= {quo_src[DIST_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign root = quo_ff[STEPS-1];
endmodule
`default_nettype wire

[tb/tb_rvb_pkg.sv]
// Testbench package for the radial vignette blend: pixel and result beat types
// and the vignette predictor. Depends on rvb_pkg.
`timescale 1ns / 1ps
package tb_rvb_pkg;
   import rvb_pkg::*;

   typedef struct {
      bit [COORD_BITS-1:0] px;
      bit [COORD_BITS-1:0] py;
      bit [15:0]           red;
      bit [15:0]           green;
      bit [15:0]           blue;
      bit [15:0]           alpha;
   } pixel_type;

   typedef struct {
      bit [15:0] red;
      bit [15:0] green;
      bit [15:0] blue;
      bit [15:0] alpha;
   } shaded_type;

   typedef struct {
      bit [12:0] width;
      bit [12:0] height;
      bit [19:0] inner;
      bit [24:0] falloff_inv;
      bit [15:0] amount;
      bit [15:0] tint_r;
      bit [15:0] tint_g;
      bit [15:0] tint_b;
   } vignette_cfg_type;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned step;
      root = 0;
      step = 64'd1 << 62;
      while (step > n) step >>= 2;
      while (step != 0) begin
         if (n >= root + step) begin
            n -= root + step;
            root = (root >> 1) + step;
         end else begin
            root >>= 1;
         end
         step >>= 2;
      end
      return root;
   endfunction

   function automatic bit [15:0] mix_toward_tint(longint unsigned c, longint unsigned tint,
                                                longint unsigned t);
      longint unsigned r;
      r = (c * (65536 - t) + tint * t + 32768) >> 16;
      return r[15:0];
   endfunction

   function automatic shaded_type shade_pixel(vignette_cfg_type cfg, pixel_type p);
      shaded_type o;
      longint unsigned w, h, inv, dx, dy, radial, v, s, t;
      o.alpha = p.alpha;
      if (p.alpha == 0) begin
         o.red = p.red;
         o.green = p.green;
         o.blue = p.blue;
         return o;
      end
      w = (cfg.width > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : cfg.width;
      h = (cfg.height > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : cfg.height;
      inv = (cfg.falloff_inv > ONE_Q24) ? ONE_Q24 : cfg.falloff_inv;
      dx = (p.px * 16 >= w * 8) ? p.px * 16 - w * 8 : w * 8 - p.px * 16;
      dy = (p.py * 16 >= h * 8) ? p.py * 16 - h * 8 : h * 8 - p.py * 16;
      radial = int_sqrt(dx * dx + dy * dy);
      if (radial <= cfg.inner) begin
         v = 0;
      end else begin
         v = ((radial - cfg.inner) * inv) >> 12;
         if (v > 65536) v = 65536;
      end
      s = (((v * v) >> 16) * (3 * 65536 - 2 * v)) >> 16;
      if (s > 65536) s = 65536;
      t = (s * cfg.amount) >> 16;
      o.red = mix_toward_tint(p.red, cfg.tint_r, t);
      o.green = mix_toward_tint(p.green, cfg.tint_g, t);
      o.blue = mix_toward_tint(p.blue, cfg.tint_b, t);
      return o;
   endfunction
endpackage

[tb/tb_top.sv]
// Top-level testbench for radial_vignette_blend: directed and random pixel
// streams checked against an in-bench predictor. Depends on rvb_pkg, rvb_if,
// tb_rvb_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
   import rvb_pkg::*;
   import tb_rvb_pkg::*;

   localparam int PIPE_DEPTH = 27;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rvb_req_if req ();
   rvb_rsp_if rsp ();
   rvb_csr_if csr ();

   radial_vignette_blend dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // Shadow copy of the register file, written alongside every csr beat.
   vignette_cfg_type cfg;
   shaded_type expected_pixels[$];
   int mismatch_count = 0;
   int unexpected_count = 0;
   int checked_count = 0;
   longint cycle_count = 0;

   // Idling controls. Bursts are on by default; the final phase turns them off.
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int receiver_hold = 0;

   initial begin
      req.valid = 1'b0;
      req.pixel_x = '0;
      req.pixel_y = '0;
      req.in_red = '0;
      req.in_green = '0;
      req.in_blue = '0;
      req.in_alpha = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = REG_FRAME_WIDTH;
      csr.data = '0;
   end

   // Watchdog: a hung pipeline or lost beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: random ready bursts, plus an optional long hold-off requested by a
   // test so that the pipeline fills and stalls its input.
   always @(posedge clock) begin
      int burst;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (receiver_hold > 0) begin
         rsp.ready <= 1'b0;
         receiver_hold <= receiver_hold - 1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
         burst = $urandom_range(1, 8);
         rsp.ready <= 1'b0;
         repeat (burst) @(posedge clock);
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Result checker: every rsp beat is compared to the oldest prediction.
   always @(posedge clock) begin
      shaded_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_pixels.size() == 0) begin
            unexpected_count++;
            if (unexpected_count + mismatch_count <= 10)
               $display("Unexpected result beat: %h %h %h %h", rsp.out_red,
                        rsp.out_green, rsp.out_blue, rsp.out_alpha);
         end else begin
            want = expected_pixels.pop_front();
            checked_count++;
            if (rsp.out_red !== want.red || rsp.out_green !== want.green ||
                rsp.out_blue !== want.blue || rsp.out_alpha !== want.alpha) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= 10)
                  $display("Mismatch on result %0d: expected rgba %h %h %h %h, got %h %h %h %h",
                           checked_count, want.red, want.green, want.blue, want.alpha,
                           rsp.out_red, rsp.out_green, rsp.out_blue, rsp.out_alpha);
            end
         end
      end
   end

   // Sends one pixel beat, waits for acceptance and records the prediction.
   // Valid is only lowered when an idle burst follows, so back-to-back beats
   // never see a low-then-high in one step.
   task automatic send_pixel(pixel_type p);
      int gap;
      req.valid <= 1'b1;
      req.pixel_x <= p.px;
      req.pixel_y <= p.py;
      req.in_red <= p.red;
      req.in_green <= p.green;
      req.in_blue <= p.blue;
      req.in_alpha <= p.alpha;
      do @(posedge clock); while (!req.ready);
      expected_pixels.push_back(shade_pixel(cfg, p));
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until all predictions are consumed, then lets the pipe drain.
   task automatic drain_pipeline();
      req.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // Writes one register over the csr channel; only called with the block idle.
   // Valid stays high so that writes follow back to back; the caller lowers it.
   task automatic write_reg(reg_index_type idx, bit [CSR_DATA_BITS-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         REG_FRAME_WIDTH:   cfg.width = value[12:0];
         REG_FRAME_HEIGHT:  cfg.height = value[12:0];
         REG_INNER_RADIUS:  cfg.inner = value[19:0];
         REG_INVERSE_RANGE: cfg.falloff_inv = value[24:0];
         REG_BLEND_AMOUNT:  cfg.amount = value[15:0];
         REG_TINT_RED:      cfg.tint_r = value[15:0];
         REG_TINT_GREEN:    cfg.tint_g = value[15:0];
         REG_TINT_BLUE:     cfg.tint_b = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_vignette(vignette_cfg_type c);
      write_reg(REG_FRAME_WIDTH, CSR_DATA_BITS'(c.width));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_BITS'(c.height));
      write_reg(REG_INNER_RADIUS, CSR_DATA_BITS'(c.inner));
      write_reg(REG_INVERSE_RANGE, CSR_DATA_BITS'(c.falloff_inv));
      write_reg(REG_BLEND_AMOUNT, CSR_DATA_BITS'(c.amount));
      write_reg(REG_TINT_RED, CSR_DATA_BITS'(c.tint_r));
      write_reg(REG_TINT_GREEN, CSR_DATA_BITS'(c.tint_g));
      write_reg(REG_TINT_BLUE, CSR_DATA_BITS'(c.tint_b));
      csr.valid <= 1'b0;
   endtask

   function automatic pixel_type random_pixel(int span_x, int span_y);
      pixel_type p;
      // Mostly pixels inside the frame; a few anywhere in the coordinate range.
      if ($urandom_range(0, 9) == 0) begin
         p.px = COORD_BITS'($urandom);
         p.py = COORD_BITS'($urandom);
      end else begin
         p.px = COORD_BITS'($urandom_range(0, span_x - 1));
         p.py = COORD_BITS'($urandom_range(0, span_y - 1));
      end
      p.red = 16'($urandom);
      p.green = 16'($urandom);
      p.blue = 16'($urandom);
      p.alpha = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
      return p;
   endfunction

   function automatic vignette_cfg_type random_cfg();
      vignette_cfg_type c;
      c.width = 13'($urandom_range(1, 4096));
      c.height = 13'($urandom_range(1, 4096));
      c.inner = 20'($urandom_range(0, 20000));
      c.falloff_inv = 25'($urandom_range(1000, 300000));
      c.amount = 16'($urandom);
      c.tint_r = 16'($urandom);
      c.tint_g = 16'($urandom);
      c.tint_b = 16'($urandom);
      return c;
   endfunction

   // Reset defaults: amount zero, so every pixel should come back unchanged.
   task automatic test_reset_defaults();
      cfg = '{width: 1920, height: 1080, inner: 0, falloff_inv: ONE_Q24, amount: 0,
              tint_r: 0, tint_g: 0, tint_b: 0};
      for (int i = 0; i < 4; i++) send_pixel(random_pixel(1920, 1080));
      drain_pipeline();
   endtask

   // Directed corners: field extremes, alpha zero, centre pixel, far outside,
   // oversize frame, zero frame, inverse range above one, full amount.
   task automatic test_directed_corners();
      pixel_type p;
      program_vignette('{width: 13'h1FFF, height: 0, inner: 0, falloff_inv: 25'h1FFFFFF,
                         amount: 16'hFFFF, tint_r: 16'hFFFF, tint_g: 0, tint_b: 16'h8000});
      p = '{px: 12'hFFF, py: 12'hFFF, red: 0, green: 16'hFFFF, blue: 16'h1234, alpha: 16'hFFFF};
      send_pixel(p);
      p = '{px: 0, py: 0, red: 16'hFFFF, green: 0, blue: 16'hFFFF, alpha: 1};
      send_pixel(p);
      p = '{px: 2048, py: 0, red: 16'hAAAA, green: 16'h5555, blue: 0, alpha: 0};
      send_pixel(p);
      p = '{px: 12'hFFF, py: 0, red: 16'h5555, green: 16'hAAAA, blue: 16'hFFFF, alpha: 16'h8000};
      send_pixel(p);
      drain_pipeline();
      program_vignette('{width: 64, height: 48, inner: 16'd100, falloff_inv: 25'd1 << 20,
                         amount: 16'h8000, tint_r: 0, tint_g: 16'hFFFF, tint_b: 16'h00FF});
      for (int y = 0; y < 48; y += 11) begin
         p = '{px: 32, py: COORD_BITS'(y), red: 16'hFFFF, green: 16'h0, blue: 16'h7FFF,
               alpha: 16'hFFFF};
         send_pixel(p);
      end
      p = '{px: 32, py: 24, red: 16'h1111, green: 16'h2222, blue: 16'h3333, alpha: 16'hFFFF};
      send_pixel(p);
      drain_pipeline();
      program_vignette('{width: 1, height: 1, inner: 20'hFFFFF, falloff_inv: 0,
                         amount: 16'hFFFF, tint_r: 16'hFFFF, tint_g: 16'hFFFF, tint_b: 16'hFFFF});
      send_pixel('{px: 12'hFFF, py: 12'hFFF, red: 0, green: 0, blue: 0, alpha: 16'hFFFF});
      send_pixel('{px: 0, py: 0, red: 16'h1, green: 16'h2, blue: 16'h3, alpha: 16'h4});
      drain_pipeline();
   endtask

   // Long receiver hold-off while the sender keeps offering, so the pipe fills
   // and req ready drops; then a pause until every result is back.
   task automatic test_backpressure();
      program_vignette(random_cfg());
      receiver_hold = 200;
      for (int i = 0; i < 60; i++) send_pixel(random_pixel(cfg.width, cfg.height));
      drain_pipeline();
   endtask

   // Random phases, each under its own register setting, the last without gaps.
   task automatic test_random_phases(int phases, int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         program_vignette(random_cfg());
         if (ph == phases - 1) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end
         for (int i = 0; i < per_phase; i++) send_pixel(random_pixel(cfg.width, cfg.height));
         drain_pipeline();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_corners();
      test_backpressure();
      test_random_phases(10, 145);
      $display("Checked %0d pixels over reset, corner, stall and random settings.",
               checked_count);
      if (mismatch_count == 0 && unexpected_count == 0 && expected_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d unexpected beats, %0d missing", mismatch_count,
                  unexpected_count, expected_pixels.size());
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/rvb_pkg.sv
rtl/rvb_if.sv
rtl/rvb_isqrt.sv
rtl/radial_vignette_blend.sv
tb/tb_rvb_pkg.sv
tb/tb_top.sv
